// File: src/ptra_pkg.sv
// Shared types and constants for the planar tile row to atlas pixel block.
`timescale 1ns / 1ps

package ptra_pkg;

    // Tile geometry is fixed at eight pixels on a side.
    localparam int TILE_SIZE = 8;
    localparam int COL_W = $clog2(TILE_SIZE);
    localparam int CELL_W = 4;
    localparam int COORD_W = 7;
    localparam int PLANE_W = 8;
    localparam int TILE_W = 8;
    localparam int TILE_COUNT = 1 << TILE_W;
    localparam int DEFAULT_GRID_COLUMNS = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CHAN_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ZERO  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_MODE = 3'd4;

    localparam logic [CFG_DATA_W-1:0] COLOR_ZERO_RESET  = 24'hFCD8A8;
    localparam logic [CFG_DATA_W-1:0] COLOR_ONE_RESET   = 24'hFCFCFC;
    localparam logic [CFG_DATA_W-1:0] COLOR_TWO_RESET   = 24'h5C5C5C;
    localparam logic [CFG_DATA_W-1:0] COLOR_THREE_RESET = 24'h0058F8;

    localparam logic [1:0] PIX_INDEX_ZERO = 2'd0;
    localparam logic [1:0] PIX_INDEX_ONE  = 2'd1;
    localparam logic [1:0] PIX_INDEX_TWO  = 2'd2;
    localparam logic [1:0] PIX_INDEX_THREE = 2'd3;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE      = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_TRANSPARENT = 8'h00;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(TILE_SIZE - 1);

    // One tile row after coordinate mapping.
    typedef struct packed {
        logic [CELL_W-1:0]  x_cell;
        logic [COORD_W-1:0] y;
        logic [PLANE_W-1:0] plane_low;
        logic [PLANE_W-1:0] plane_high;
    } row_beat_t;

    // One pixel leaving the serializer.
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [1:0]         index;
        logic               last;
    } pix_beat_t;

endpackage

// File: src/planar_tile_row_to_atlas_pixels.sv
// Top level: decodes two-bit planar tile rows into colored atlas pixels.
`timescale 1ns / 1ps

//  Channel   Ports                                             Beat taken when
//  -------   -----------------------------------------------   ---------------------
//  row in    start, busy, tile_number, row_in_tile,            start high, busy low
//            plane_low, plane_high
//  pixel out pixel_strobe, pixel_x, pixel_y, red, green,       pixel_strobe high
//            blue, alpha, last_pixel
//  config    cfg_we, cfg_index, cfg_data                       cfg_we high
//
// Each accepted row yields eight pixel beats on consecutive cycles, the
// leftmost pixel first, and last_pixel marks the eighth. The first pixel
// passes through the coordinate register, the serializer and the output
// register on its way to the output ports. The serializer emits one pixel
// a cycle while it holds a row; a second row waits in the coordinate
// register and follows without a gap.
// busy is high while a row waits there and a row in the serializer is not on
// its last pixel. The receiver cannot stall, so nothing inside ever holds a pixel.
// rst_n clears all valid bits at once and restores the register defaults.
// Configuration should be written only while no row is in flight.

module planar_tile_row_to_atlas_pixels #(
    parameter int GRID_COLUMNS = ptra_pkg::DEFAULT_GRID_COLUMNS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ptra_pkg::TILE_W-1:0]      tile_number,
    input  logic [ptra_pkg::COL_W-1:0]       row_in_tile,
    input  logic [ptra_pkg::PLANE_W-1:0]     plane_low,
    input  logic [ptra_pkg::PLANE_W-1:0]     plane_high,
    input  logic                             cfg_we,
    input  logic [ptra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ptra_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             pixel_strobe,
    output logic [ptra_pkg::COORD_W-1:0]     pixel_x,
    output logic [ptra_pkg::COORD_W-1:0]     pixel_y,
    output logic [ptra_pkg::CHAN_W-1:0]      red,
    output logic [ptra_pkg::CHAN_W-1:0]      green,
    output logic [ptra_pkg::CHAN_W-1:0]      blue,
    output logic [ptra_pkg::CHAN_W-1:0]      alpha,
    output logic                             last_pixel
);
    import ptra_pkg::*;

    logic      accept;
    logic      ser_free;
    logic      row_valid;
    logic      sprite_mode;
    row_beat_t row_beat;
    pix_beat_t pix_beat;

    // A waiting row moves into the serializer whenever it is free, so the
    // input side only holds off when both stages are occupied.
    assign busy   = row_valid && !ser_free;
    assign accept = start && !busy;

    ptra_coord #(
        .GRID_COLUMNS (GRID_COLUMNS)
    ) u_coord (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .drain       (ser_free),
        .sprite_mode (sprite_mode),
        .tile_number (tile_number),
        .row_in_tile (row_in_tile),
        .plane_low   (plane_low),
        .plane_high  (plane_high),
        .row_valid   (row_valid),
        .row_beat    (row_beat)
    );

    ptra_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_beat  (row_beat),
        .free      (ser_free),
        .pix_beat  (pix_beat)
    );

    ptra_color u_color (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pix_beat     (pix_beat),
        .sprite_mode  (sprite_mode),
        .pixel_strobe (pixel_strobe),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .last_pixel   (last_pixel)
    );

    // An accepted row is always held in the coordinate register next cycle.
    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> row_valid)
        else $error("accepted row was not captured");

    // The pixels of one row come out on back-to-back cycles.
    a_row_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_strobe && !last_pixel) |=> pixel_strobe)
        else $error("gap inside a pixel row");

    // Within a row the atlas row stays put and the column steps by one.
    a_row_same_y: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_strobe && !last_pixel) |=> (pixel_y == $past(pixel_y)))
        else $error("pixel row changed inside a tile row");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_strobe && !last_pixel) |=>
            (pixel_x[COL_W-1:0] == COL_W'($past(pixel_x[COL_W-1:0]) + COL_W'(1))))
        else $error("pixel column did not advance by one");

endmodule

// File: src/ptra_coord.sv
// Input stage: maps tile number and row to atlas coordinates and holds the row.
`timescale 1ns / 1ps

module ptra_coord #(
    parameter int GRID_COLUMNS = ptra_pkg::DEFAULT_GRID_COLUMNS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         drain,
    input  logic                         sprite_mode,
    input  logic [ptra_pkg::TILE_W-1:0]  tile_number,
    input  logic [ptra_pkg::COL_W-1:0]   row_in_tile,
    input  logic [ptra_pkg::PLANE_W-1:0] plane_low,
    input  logic [ptra_pkg::PLANE_W-1:0] plane_high,
    output logic                         row_valid,
    output ptra_pkg::row_beat_t          row_beat
);
    import ptra_pkg::*;

    logic [CELL_W-1:0] quo_tbl [TILE_COUNT];
    logic [CELL_W-1:0] rem_tbl [TILE_COUNT];
    logic [TILE_W-1:0] dividend;
    logic [CELL_W-1:0] quo;
    logic [CELL_W-1:0] rem;
    logic              row_valid_reg;
    logic              row_valid_next;
    row_beat_t         row_beat_reg;
    row_beat_t         row_beat_next;

    // Quotient and remainder by the atlas width, worked out at elaboration.
    // Only the low bits survive the seven bit wrap of the coordinates.
    genvar g;
    for (g = 0; g < TILE_COUNT; g++) begin : g_div
        assign quo_tbl[g] = CELL_W'(g / GRID_COLUMNS);
        assign rem_tbl[g] = CELL_W'(g % GRID_COLUMNS);
    end

    // In sprite mode two tiles share one cell of the grid.
    assign dividend = sprite_mode ? {1'b0, tile_number[TILE_W-1:1]} : tile_number;
    assign quo = quo_tbl[dividend];
    assign rem = rem_tbl[dividend];

    always_comb
    begin
        row_beat_next            = row_beat_reg;
        row_beat_next.x_cell     = rem;
        row_beat_next.plane_low  = plane_low;
        row_beat_next.plane_high = plane_high;
        if (sprite_mode)
        begin
            row_beat_next.y = {quo[CELL_W-2:0], tile_number[0], row_in_tile};
        end
        else
        begin
            row_beat_next.y = {quo, row_in_tile};
        end
        if (load)
        begin
            row_valid_next = 1'b1;
        end
        else if (drain)
        begin
            row_valid_next = 1'b0;
        end
        else
        begin
            row_valid_next = row_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_beat_reg <= row_beat_next;
        end
    end

    assign row_valid = row_valid_reg;
    assign row_beat  = row_beat_reg;

endmodule

// File: src/ptra_shift.sv
// Serializer: shifts one tile row out as eight pixel indexes, leftmost first.
`timescale 1ns / 1ps

module ptra_shift (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                row_valid,
    input  ptra_pkg::row_beat_t row_beat,
    output logic                free,
    output ptra_pkg::pix_beat_t pix_beat
);
    import ptra_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [PLANE_W-1:0] low_reg;
    logic [PLANE_W-1:0] low_next;
    logic [PLANE_W-1:0] high_reg;
    logic [PLANE_W-1:0] high_next;
    logic [CELL_W-1:0]  cell_reg;
    logic [CELL_W-1:0]  cell_next;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] y_next;

    // A new row may enter on the same edge that the last pixel leaves.
    assign free = !valid_reg || (col_reg == LAST_COL);

    always_comb
    begin
        valid_next = valid_reg;
        col_next   = col_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        cell_next  = cell_reg;
        y_next     = y_reg;
        if (free)
        begin
            valid_next = row_valid;
            col_next   = '0;
            low_next   = row_beat.plane_low;
            high_next  = row_beat.plane_high;
            cell_next  = row_beat.x_cell;
            y_next     = row_beat.y;
        end
        else
        begin
            col_next  = col_reg + COL_W'(1);
            low_next  = {low_reg[PLANE_W-2:0], 1'b0};
            high_next = {high_reg[PLANE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            col_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
        cell_reg <= cell_next;
        y_reg    <= y_next;
    end

    assign pix_beat.valid = valid_reg;
    assign pix_beat.x     = {cell_reg, col_reg};
    assign pix_beat.y     = y_reg;
    assign pix_beat.index = {high_reg[PLANE_W-1], low_reg[PLANE_W-1]};
    assign pix_beat.last  = (col_reg == LAST_COL);

endmodule

// File: src/ptra_color.sv
// Color registers and the output stage that turns a pixel index into RGBA.
`timescale 1ns / 1ps

module ptra_color (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ptra_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  ptra_pkg::pix_beat_t             pix_beat,
    output logic                            sprite_mode,
    output logic                            pixel_strobe,
    output logic [ptra_pkg::COORD_W-1:0]    pixel_x,
    output logic [ptra_pkg::COORD_W-1:0]    pixel_y,
    output logic [ptra_pkg::CHAN_W-1:0]     red,
    output logic [ptra_pkg::CHAN_W-1:0]     green,
    output logic [ptra_pkg::CHAN_W-1:0]     blue,
    output logic [ptra_pkg::CHAN_W-1:0]     alpha,
    output logic                            last_pixel
);
    import ptra_pkg::*;

    logic [CFG_DATA_W-1:0] color_zero_reg;
    logic [CFG_DATA_W-1:0] color_one_reg;
    logic [CFG_DATA_W-1:0] color_two_reg;
    logic [CFG_DATA_W-1:0] color_three_reg;
    logic                  sprite_mode_reg;
    logic [CFG_DATA_W-1:0] rgb;
    logic [CHAN_W-1:0]     alpha_next;
    logic                  strobe_reg;
    logic [COORD_W-1:0]    x_reg;
    logic [COORD_W-1:0]    y_reg;
    logic [CFG_DATA_W-1:0] rgb_reg;
    logic [CHAN_W-1:0]     alpha_reg;
    logic                  last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_zero_reg  <= COLOR_ZERO_RESET;
            color_one_reg   <= COLOR_ONE_RESET;
            color_two_reg   <= COLOR_TWO_RESET;
            color_three_reg <= COLOR_THREE_RESET;
            sprite_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLOR_ZERO:  color_zero_reg  <= cfg_data;
                REG_COLOR_ONE:   color_one_reg   <= cfg_data;
                REG_COLOR_TWO:   color_two_reg   <= cfg_data;
                REG_COLOR_THREE: color_three_reg <= cfg_data;
                REG_SPRITE_MODE: sprite_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (pix_beat.index)
            PIX_INDEX_ZERO:  rgb = color_zero_reg;
            PIX_INDEX_ONE:   rgb = color_one_reg;
            PIX_INDEX_TWO:   rgb = color_two_reg;
            PIX_INDEX_THREE: rgb = color_three_reg;
            default:         rgb = color_zero_reg;
        endcase
        // Index zero is see-through only for sprites.
        if (sprite_mode_reg && (pix_beat.index == PIX_INDEX_ZERO))
        begin
            alpha_next = ALPHA_TRANSPARENT;
        end
        else
        begin
            alpha_next = ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= pix_beat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= pix_beat.x;
        y_reg     <= pix_beat.y;
        rgb_reg   <= rgb;
        alpha_reg <= alpha_next;
        last_reg  <= pix_beat.last;
    end

    assign sprite_mode  = sprite_mode_reg;
    assign pixel_strobe = strobe_reg;
    assign pixel_x      = x_reg;
    assign pixel_y      = y_reg;
    assign red          = rgb_reg[23:16];
    assign green        = rgb_reg[15:8];
    assign blue         = rgb_reg[7:0];
    assign alpha        = alpha_reg;
    assign last_pixel   = last_reg;

endmodule
